[hdl/csmd_pkg.sv]
`default_nettype none

package csmd_pkg;

    // Request opcodes and button codes
    localparam logic       OP_TICK  = 1'b0;
    localparam logic       OP_CLICK = 1'b1;
    localparam logic [1:0] KEY_OK   = 2'd0;
    localparam logic [1:0] KEY_UP   = 2'd1;
    localparam logic [1:0] KEY_DOWN = 2'd2;

    // Edit field codes
    localparam logic [1:0] FIELD_NONE    = 2'd0;
    localparam logic [1:0] FIELD_HOURS   = 2'd1;
    localparam logic [1:0] FIELD_MINUTES = 2'd2;
    localparam logic [1:0] FIELD_SECONDS = 2'd3;

    // Configuration register indexes
    localparam int          CFG_IDX_W          = 3;
    localparam int          CFG_DATA_W         = 16;
    localparam logic [2:0]  CFG_MENU_BLINK     = 3'd0;
    localparam logic [2:0]  CFG_DOT_BLINK      = 3'd1;
    localparam logic [2:0]  CFG_RTC_POLL       = 3'd2;
    localparam logic [2:0]  CFG_REPEAT_DELAY   = 3'd3;
    localparam logic [2:0]  CFG_REPEAT_STEP    = 3'd4;
    localparam logic [2:0]  CFG_CYCLE_STEP     = 3'd5;
    localparam logic [2:0]  CFG_CYCLE_PASSES   = 3'd6;

    // Configuration reset values
    localparam logic [15:0] RST_MENU_BLINK   = 16'd100;
    localparam logic [15:0] RST_DOT_BLINK    = 16'd250;
    localparam logic [7:0]  RST_RTC_POLL     = 8'd200;
    localparam logic [15:0] RST_REPEAT_DELAY = 16'd300;
    localparam logic [15:0] RST_REPEAT_STEP  = 16'd100;
    localparam logic [7:0]  RST_CYCLE_STEP   = 8'd10;
    localparam logic [3:0]  RST_CYCLE_PASSES = 4'd3;

    localparam logic [5:0]  ENABLES_ALL  = 6'h3F;
    localparam logic [4:0]  HOURS_MAX    = 5'd23;
    localparam logic [5:0]  MINSEC_MAX   = 6'd59;
    localparam logic [3:0]  DIGIT_LAST   = 4'd9;

    typedef struct packed {
        logic       opcode;
        logic [1:0] key;
        logic       held_up;
        logic       held_down;
        logic [6:0] rtc_seconds_bcd;
        logic [6:0] rtc_minutes_bcd;
        logic [5:0] rtc_hours_bcd;
    } t_in;

    typedef struct packed {
        logic [3:0]  digit_hour_tens;
        logic [3:0]  digit_hour_ones;
        logic [3:0]  digit_minute_tens;
        logic [3:0]  digit_minute_ones;
        logic [3:0]  digit_second_tens;
        logic [3:0]  digit_second_ones;
        logic [5:0]  digit_enables;
        logic        dot_on;
        logic        rtc_write;
        logic [21:0] rtc_write_time;
    } t_out;

    typedef struct packed {
        logic [15:0] menu_blink_ticks;
        logic [15:0] dot_blink_ticks;
        logic [7:0]  rtc_poll_ticks;
        logic [15:0] repeat_delay_ticks;
        logic [15:0] repeat_step_ticks;
        logic [7:0]  cycle_step_ticks;
        logic [3:0]  cycle_passes;
    } t_cfg;

    typedef struct packed {
        logic        in_menu;
        logic [1:0]  edit_field;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds_now;
        logic [15:0] blink_count;
        logic        field_visible;
        logic        dot_state;
        logic [15:0] held_count;
        logic [15:0] repeat_count;
        logic [7:0]  poll_count;
        logic        cycling;
        logic [5:0]  last_minutes;
        logic [4:0]  last_hours;
        logic [7:0]  cycle_tick_count;
        logic [3:0]  cycle_digit;
        logic [3:0]  cycle_pass;
        logic [5:0]  enables_reg;
        logic [23:0] shown_digits;
    } t_state;

    // Binary 0..63 to {tens, ones}; tens = v*205 >> 11 is exact below 180
    function automatic logic [7:0] bin_to_bcd(input logic [5:0] v);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  ones;
        prod     = 14'(v) * 14'd205;
        tens     = {1'b0, prod[13:11]};
        tens_x10 = {1'b0, tens[2:0], 3'b000} + {2'b00, tens[2:0], 1'b0};
        ones     = 7'(v) - tens_x10;
        return {tens, ones[3:0]};
    endfunction

    // BCD byte to binary, tens*10 + ones
    function automatic logic [6:0] bcd_to_bin(input logic [2:0] tens, input logic [3:0] ones);
        return {1'b0, tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, ones};
    endfunction

endpackage

`default_nettype wire

[hdl/csmd_step.sv]
`default_nettype none

module csmd_step
    import csmd_pkg::*;
(
    input  wire t_in    i_req,
    input  wire t_cfg   i_cfg,
    input  wire t_state i_state,
    output t_state      o_state,
    output t_out        o_result
);

    t_state     s;
    logic       wr;
    logic       fire;
    logic [1:0] fvis;
    logic [6:0] sec_bin;
    logic [6:0] min_bin;
    logic [6:0] hr_bin;
    logic [7:0] hb;
    logic [7:0] mb;
    logic [7:0] sb;
    logic [3:0] cd;

    // Apply one up or down step to the field under edit
    function automatic t_state step_field(input t_state st, input logic up);
        t_state r;
        r = st;
        case (st.edit_field)
            FIELD_HOURS: begin
                if (up) r.hours = (st.hours >= HOURS_MAX) ? 5'd0 : st.hours + 5'd1;
                else    r.hours = (st.hours == 5'd0) ? HOURS_MAX : st.hours - 5'd1;
            end
            FIELD_MINUTES: begin
                if (up) r.minutes = (st.minutes >= MINSEC_MAX) ? 6'd0 : st.minutes + 6'd1;
                else    r.minutes = (st.minutes == 6'd0) ? MINSEC_MAX : st.minutes - 6'd1;
            end
            FIELD_SECONDS: begin
                if (up) r.seconds_now = (st.seconds_now >= MINSEC_MAX) ? 6'd0
                                        : st.seconds_now + 6'd1;
                else    r.seconds_now = (st.seconds_now == 6'd0) ? MINSEC_MAX
                                        : st.seconds_now - 6'd1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always_comb begin
        s       = i_state;
        wr      = 1'b0;
        fire    = 1'b0;
        fvis    = 2'b00;
        sec_bin = bcd_to_bin(i_req.rtc_seconds_bcd[6:4], i_req.rtc_seconds_bcd[3:0]);
        min_bin = bcd_to_bin(i_req.rtc_minutes_bcd[6:4], i_req.rtc_minutes_bcd[3:0]);
        hr_bin  = bcd_to_bin({1'b0, i_req.rtc_hours_bcd[5:4]}, i_req.rtc_hours_bcd[3:0]);

        if (i_req.opcode == OP_CLICK) begin
            case (i_req.key)
                KEY_OK: begin
                    s.in_menu    = 1'b1;
                    s.edit_field = i_state.edit_field + 2'd1;
                    if (s.edit_field == FIELD_NONE) begin
                        s.in_menu     = 1'b0;
                        s.blink_count = 16'd0;
                        s.enables_reg = ENABLES_ALL;
                        wr            = 1'b1;
                    end
                end
                KEY_UP, KEY_DOWN: begin
                    s.blink_count   = 16'd0;
                    s.field_visible = 1'b1;
                    s = step_field(s, i_req.key == KEY_UP);
                end
                default: begin
                end
            endcase
        end else if (i_state.in_menu) begin
            s.dot_state = 1'b0;
            if (!i_req.held_up && !i_req.held_down) begin
                s.blink_count = i_state.blink_count + 16'd1;
                if (s.blink_count >= i_cfg.menu_blink_ticks) begin
                    s.blink_count   = 16'd0;
                    s.field_visible = ~i_state.field_visible;
                end
            end
            fvis = s.field_visible ? 2'b11 : 2'b00;
            case (i_state.edit_field)
                FIELD_HOURS:   s.enables_reg = {4'b1111, fvis};
                FIELD_MINUTES: s.enables_reg = {2'b11, fvis, 2'b11};
                FIELD_SECONDS: s.enables_reg = {fvis, 4'b1111};
                default:       s.enables_reg = i_state.enables_reg;
            endcase
            if (i_req.held_up || i_req.held_down) begin
                if (i_state.held_count > i_cfg.repeat_delay_ticks) begin
                    s.repeat_count = i_state.repeat_count + 16'd1;
                    if (s.repeat_count >= i_cfg.repeat_step_ticks) begin
                        s.repeat_count = 16'd0;
                        fire           = 1'b1;
                    end
                end
                if (fire) s = step_field(s, i_req.held_up);
                if (i_state.held_count != 16'hFFFF) s.held_count = i_state.held_count + 16'd1;
            end else begin
                s.held_count = 16'd0;
            end
        end else begin
            // colon blink
            s.blink_count = i_state.blink_count + 16'd1;
            if (s.blink_count >= i_cfg.dot_blink_ticks) begin
                s.blink_count = 16'd0;
                s.dot_state   = ~i_state.dot_state;
            end
            // time chip sample, saturated to state width
            s.poll_count = i_state.poll_count + 8'd1;
            if (s.poll_count >= i_cfg.rtc_poll_ticks) begin
                s.poll_count  = 8'd0;
                s.seconds_now = sec_bin[6] ? 6'd63 : sec_bin[5:0];
                s.minutes     = min_bin[6] ? 6'd63 : min_bin[5:0];
                s.hours       = (hr_bin[6:5] != 2'b00) ? 5'd31 : hr_bin[4:0];
            end
            // digit cycling on hour or minute change
            if (i_state.last_minutes != s.minutes || i_state.last_hours != s.hours) begin
                s.cycling = 1'b1;
                if (i_state.cycle_pass < i_cfg.cycle_passes) begin
                    s.cycle_tick_count = i_state.cycle_tick_count + 8'd1;
                    if (s.cycle_tick_count >= i_cfg.cycle_step_ticks) begin
                        s.cycle_tick_count = 8'd0;
                        if (i_state.cycle_digit >= DIGIT_LAST) begin
                            s.cycle_digit = 4'd0;
                            s.cycle_pass  = i_state.cycle_pass + 4'd1;
                        end else begin
                            s.cycle_digit = i_state.cycle_digit + 4'd1;
                        end
                    end
                end else begin
                    s.cycle_pass       = 4'd0;
                    s.cycle_digit      = 4'd0;
                    s.cycle_tick_count = 8'd0;
                    s.cycling          = 1'b0;
                    s.last_minutes     = s.minutes;
                    s.last_hours       = s.hours;
                end
            end
        end

        hb = bin_to_bcd({1'b0, s.hours});
        mb = bin_to_bcd(s.minutes);
        sb = bin_to_bcd(s.seconds_now);
        cd = s.cycle_digit;

        // digits latch only on ticks
        if (i_req.opcode == OP_TICK) begin
            if (s.cycling) s.shown_digits = {cd, cd, cd, cd, cd, cd};
            else           s.shown_digits = {sb[3:0], sb[7:4], mb[3:0], mb[7:4],
                                             hb[3:0], hb[7:4]};
        end

        o_state                    = s;
        o_result.digit_hour_tens   = s.shown_digits[3:0];
        o_result.digit_hour_ones   = s.shown_digits[7:4];
        o_result.digit_minute_tens = s.shown_digits[11:8];
        o_result.digit_minute_ones = s.shown_digits[15:12];
        o_result.digit_second_tens = s.shown_digits[19:16];
        o_result.digit_second_ones = s.shown_digits[23:20];
        o_result.digit_enables     = s.enables_reg;
        o_result.dot_on            = s.dot_state;
        o_result.rtc_write         = wr;
        o_result.rtc_write_time    = wr ? {hb[5:0], 1'b0, mb[6:0], 1'b0, sb[6:0]} : 22'd0;
    end

endmodule

`default_nettype wire

[hdl/clock_set_menu_display_controller.sv]
// The result of an accepted request is registered and shown in the following cycle.
// Throughput: one request per clock; the only limit is the single result register.
// Input stall is raised only while the result register holds an untaken result.
// Reset (i_rst_n low, synchronous): configuration returns to defaults, all display
// state clears with every digit enabled, and the result register empties.
`default_nettype none

module clock_set_menu_display_controller
    import csmd_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // request channel
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in              i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output t_out                  o_out_data,
    // configuration write port
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_out   n_result;
    t_out   r_out;
    logic   r_out_valid;
    logic   accept;

    // The result register is the only buffer: take a new request whenever it
    // is empty or is being drained in this same cycle.
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Whole next-state and result computation for one request
    csmd_step u_step (
        .i_req    (i_in_data),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Configuration registers; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.menu_blink_ticks   <= RST_MENU_BLINK;
            r_cfg.dot_blink_ticks    <= RST_DOT_BLINK;
            r_cfg.rtc_poll_ticks     <= RST_RTC_POLL;
            r_cfg.repeat_delay_ticks <= RST_REPEAT_DELAY;
            r_cfg.repeat_step_ticks  <= RST_REPEAT_STEP;
            r_cfg.cycle_step_ticks   <= RST_CYCLE_STEP;
            r_cfg.cycle_passes       <= RST_CYCLE_PASSES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MENU_BLINK:   r_cfg.menu_blink_ticks   <= i_cfg_data;
                CFG_DOT_BLINK:    r_cfg.dot_blink_ticks    <= i_cfg_data;
                CFG_RTC_POLL:     r_cfg.rtc_poll_ticks     <= i_cfg_data[7:0];
                CFG_REPEAT_DELAY: r_cfg.repeat_delay_ticks <= i_cfg_data;
                CFG_REPEAT_STEP:  r_cfg.repeat_step_ticks  <= i_cfg_data;
                CFG_CYCLE_STEP:   r_cfg.cycle_step_ticks   <= i_cfg_data[7:0];
                CFG_CYCLE_PASSES: r_cfg.cycle_passes       <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Display/menu state advances once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state             <= '0;
            r_state.enables_reg <= ENABLES_ALL;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_result;
        end
    end

endmodule

`default_nettype wire
